@@ src/pufr_pkg.sv @@
// ----------------------------------------------------------------------------
// pufr_pkg
// Types and constants shared by the rollback union-find with parity.
// ----------------------------------------------------------------------------
package pufr_pkg;

	localparam int NUM_ELEMS_DEF = 1024;

	typedef enum logic [1:0] {
		FN_FIND   = 2'd0,
		FN_UNITE  = 2'd1,
		FN_QUERY  = 2'd2,
		FN_ROLL   = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0] func;
		logic [9:0] elem_a;
		logic [9:0] elem_b;
		logic       want_same;
		logic [9:0] mark_depth;
	} req_t;

	typedef struct packed {
		logic [9:0] root;
		logic       parity;
		logic       merged;
		logic       same_set;
		logic       same_orient;
		logic [9:0] log_depth;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_SIZE_RD,
		ST_SIZE_EV,
		ST_LINK,
		ST_POP_RD,
		ST_POP_EV,
		ST_POP_PAR,
		ST_POP_WR,
		ST_DONE
	} state_t;

endpackage

@@ src/pufr_ram.sv @@
// ----------------------------------------------------------------------------
// pufr_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module pufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ src/parity_union_find_with_rollback_core.sv @@
// ----------------------------------------------------------------------------
// parity_union_find_with_rollback_core
// Disjoint-set store with parity and an undo log, held in on-chip RAMs.
// ----------------------------------------------------------------------------
// Channel  | Signals             | Handshake
// request  | start, busy, req    | taken when start && !busy
// result   | done, rsp           | one-cycle strobe, cannot be stalled
//
// Find follows one parent link per cycle (one RAM read each); the result
// strobes in the first cycle in which busy is low. Results are never stalled.
// Unite walks three times, with SIZE_RD and, for distinct roots, SIZE_EV and
// LINK before the third walk; query walks twice. Rollback pops log entries
// down to the mark depth through POP_RD, POP_EV, POP_PAR and POP_WR. After
// reset a clearing pass initializes the element RAM; busy is high meanwhile.
module parity_union_find_with_rollback_core #(
	parameter int NUM_ELEMS = pufr_pkg::NUM_ELEMS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pufr_pkg::req_t req,
	output logic           done,
	output pufr_pkg::rsp_t rsp
);

	localparam int AW = $clog2(NUM_ELEMS);
	localparam int SW = AW + 1;
	// Element word: parent, parity, size.
	localparam int EW = AW + 1 + SW;
	localparam int LW = AW + SW;
	// Reciprocal of NUM_ELEMS, exact for every 10-bit index.
	localparam int RS = 26;
	localparam logic [31:0] RM = 32'((64'd1 << RS) / 64'(NUM_ELEMS) + 64'd1);

	pufr_pkg::state_t state_q, state_d;

	logic [AW-1:0] ea_q, eb_q, cur_q, ra_q, rb_q, big_q, small_q;
	logic          pa_q, pb_q, acc_q, same_q;
	logic [1:0]    func_q;
	logic [1:0]    pass_q;
	logic [9:0]    mark_q;
	logic [AW:0]   depth_q;
	logic [SW-1:0] sza_q, szb_q;
	logic          merged_q;

	logic          e_we;
	logic [AW-1:0] e_addr;
	logic [EW-1:0] e_wdata, e_rdata;
	logic          l_we;
	logic [AW-1:0] l_addr;
	logic [LW-1:0] l_wdata, l_rdata;

	logic [AW-1:0] rd_par;
	logic          rd_pb;
	logic [SW-1:0] rd_sz;

	assign rd_par = e_rdata[EW-1 -: AW];
	assign rd_pb  = e_rdata[SW];
	assign rd_sz  = e_rdata[SW-1:0];

	pufr_ram #(.WIDTH(EW), .DEPTH(NUM_ELEMS)) u_elem (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
	);
	pufr_ram #(.WIDTH(LW), .DEPTH(NUM_ELEMS)) u_log (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
	);

	function automatic logic [AW-1:0] idx(input logic [9:0] v);
		logic [35:0] prod;
		logic [31:0] w;
		prod = 36'(v) * 36'(RM);
		w = 32'(v) - 32'(prod[35:RS]) * 32'(NUM_ELEMS);
		return w[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pufr_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM controls.
	always_comb begin
		state_d = state_q;
		e_we    = 1'b0;
		e_addr  = cur_q;
		e_wdata = '0;
		l_we    = 1'b0;
		l_addr  = depth_q[AW-1:0];
		l_wdata = {small_q, szb_q};
		unique case (state_q)
			pufr_pkg::ST_INIT: begin
				e_we    = 1'b1;
				e_wdata = {cur_q, 1'b0, SW'(1)};
				if (cur_q == AW'(NUM_ELEMS - 1)) state_d = pufr_pkg::ST_IDLE;
			end
			pufr_pkg::ST_IDLE: begin
				if (start) begin
					if (req.func == pufr_pkg::FN_ROLL) state_d = pufr_pkg::ST_POP_RD;
					else state_d = pufr_pkg::ST_WALK_RD;
				end
			end
			pufr_pkg::ST_WALK_RD: state_d = pufr_pkg::ST_WALK_EV;
			pufr_pkg::ST_WALK_EV: begin
				if (rd_par != cur_q) begin
					e_addr  = rd_par;
					state_d = pufr_pkg::ST_WALK_EV;
				end else begin
					priority if (func_q == pufr_pkg::FN_UNITE && pass_q == 2'd0)
						state_d = pufr_pkg::ST_WALK_RD;
					else if (func_q == pufr_pkg::FN_QUERY && pass_q == 2'd0)
						state_d = pufr_pkg::ST_WALK_RD;
					else if (func_q == pufr_pkg::FN_UNITE && pass_q == 2'd1)
						state_d = pufr_pkg::ST_SIZE_RD;
					else
						state_d = pufr_pkg::ST_DONE;
				end
			end
			pufr_pkg::ST_SIZE_RD: begin
				if (ra_q == rb_q) state_d = pufr_pkg::ST_WALK_RD;
				else state_d = pufr_pkg::ST_SIZE_EV;
			end
			pufr_pkg::ST_SIZE_EV: begin
				e_addr  = small_q;
				e_we    = 1'b1;
				e_wdata = {big_q, pa_q ^ pb_q ^ ~same_q, szb_q};
				state_d = pufr_pkg::ST_LINK;
			end
			pufr_pkg::ST_LINK: begin
				e_addr  = big_q;
				e_we    = 1'b1;
				e_wdata = {big_q, 1'b0, SW'(szb_q + sza_q)};
				l_we    = 1'b1;
				state_d = pufr_pkg::ST_WALK_RD;
			end
			pufr_pkg::ST_POP_RD: begin
				if (depth_q <= (AW+1)'(mark_q)) state_d = pufr_pkg::ST_DONE;
				else begin
					l_addr  = AW'(depth_q - 1'b1);
					state_d = pufr_pkg::ST_POP_EV;
				end
			end
			pufr_pkg::ST_POP_EV: begin
				e_addr  = l_rdata[LW-1 -: AW];
				state_d = pufr_pkg::ST_POP_PAR;
			end
			pufr_pkg::ST_POP_PAR: begin
				e_addr  = small_q;
				e_we    = 1'b1;
				e_wdata = {small_q, 1'b0, rd_sz};
				state_d = pufr_pkg::ST_POP_WR;
			end
			pufr_pkg::ST_POP_WR: begin
				e_addr  = big_q;
				e_we    = 1'b1;
				e_wdata = {big_q, 1'b0, szb_q};
				state_d = pufr_pkg::ST_POP_RD;
			end
			pufr_pkg::ST_DONE: state_d = pufr_pkg::ST_IDLE;
			default: state_d = pufr_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			depth_q <= '0;
			pass_q  <= '0;
		end else begin
			unique case (state_q)
				pufr_pkg::ST_INIT: cur_q <= cur_q + 1'b1;
				pufr_pkg::ST_IDLE: begin
					func_q   <= req.func;
					ea_q     <= idx(req.elem_a);
					eb_q     <= idx(req.elem_b);
					same_q   <= req.want_same;
					mark_q   <= req.mark_depth;
					cur_q    <= idx(req.elem_a);
					acc_q    <= 1'b0;
					pass_q   <= '0;
					merged_q <= 1'b0;
				end
				pufr_pkg::ST_WALK_RD: ;
				pufr_pkg::ST_WALK_EV: begin
					if (rd_par != cur_q) begin
						acc_q <= acc_q ^ rd_pb;
						cur_q <= rd_par;
					end else begin
						pass_q <= pass_q + 1'b1;
						// The first walk and the walk after a unite both land on a.
						if (pass_q != 2'd1) begin
							ra_q  <= cur_q;
							pa_q  <= acc_q;
							sza_q <= rd_sz;
							cur_q <= eb_q;
						end else begin
							rb_q  <= cur_q;
							pb_q  <= acc_q;
							szb_q <= rd_sz;
							cur_q <= ea_q;
						end
						acc_q <= 1'b0;
					end
				end
				pufr_pkg::ST_SIZE_RD: begin
					// Union by size; ties put b's root under a's.
					if (sza_q < szb_q) begin
						big_q <= rb_q; small_q <= ra_q;
						sza_q <= szb_q; szb_q <= sza_q;
					end else begin
						big_q <= ra_q; small_q <= rb_q;
					end
					pass_q <= 2'd3;
				end
				pufr_pkg::ST_SIZE_EV: begin
					// sza_q = big size, szb_q = small size; keep both for the link.
					sza_q <= szb_q;
					szb_q <= sza_q;
				end
				pufr_pkg::ST_LINK: begin
					depth_q  <= depth_q + 1'b1;
					merged_q <= 1'b1;
					acc_q    <= 1'b0;
				end
				pufr_pkg::ST_POP_RD: begin
					if (depth_q > (AW+1)'(mark_q)) depth_q <= depth_q - 1'b1;
				end
				pufr_pkg::ST_POP_EV: begin
					small_q <= l_rdata[LW-1 -: AW];
					szb_q   <= l_rdata[SW-1:0];
				end
				pufr_pkg::ST_POP_PAR: begin
					big_q <= rd_par;
					sza_q <= rd_sz;
				end
				pufr_pkg::ST_POP_WR: ;
				pufr_pkg::ST_DONE: ;
				default: ;
			endcase
		end
	end

	assign busy = (state_q != pufr_pkg::ST_IDLE);

	// Result register: strobe for one cycle after the final step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == pufr_pkg::ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pufr_pkg::ST_DONE) begin
			rsp.root        <= (func_q == pufr_pkg::FN_ROLL) ? '0 : 10'(ra_q);
			rsp.parity      <= (func_q == pufr_pkg::FN_ROLL) ? 1'b0 : pa_q;
			rsp.merged      <= merged_q;
			rsp.same_set    <= (func_q == pufr_pkg::FN_QUERY) && (ra_q == rb_q);
			rsp.same_orient <= (func_q == pufr_pkg::FN_QUERY) && (pa_q == pb_q);
			rsp.log_depth   <= 10'(depth_q);
		end
	end

endmodule

@@ src/pufr_checker.sv @@
// ----------------------------------------------------------------------------
// pufr_checker
// Port-level checks of the union-find core handshake and results.
// ----------------------------------------------------------------------------
module pufr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input pufr_pkg::rsp_t rsp
);

	// An accepted item makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");

	// A result strobe is a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	// A result arrives only once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// A result never says both merged and same set.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.merged && rsp.same_set)) else $error("merged with query flags");

endmodule

bind parity_union_find_with_rollback_core pufr_checker u_pufr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
